### rtl/psd_pkg.sv
// ----------------------------------------------------------------------------
// psd_pkg
// Shared types and constants of the per-slot duration statistics block.
// ----------------------------------------------------------------------------
package psd_pkg;

    localparam int NUM_SLOTS = 8;
    localparam int IDX_W     = $clog2(NUM_SLOTS);

    localparam int CMD_DEPTH = 2;
    localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
    localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

    localparam int OUT_DEPTH = 2;
    localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

    localparam int DIV_STEPS = 64;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic [31:0] ALL_ONES32     = 32'hFFFF_FFFF;
    localparam logic [19:0] INTERVAL_RESET = 20'd1000;

    localparam logic [1:0] ACT_SAMPLE = 2'd0;
    localparam logic [1:0] ACT_TICK   = 2'd1;
    localparam logic [1:0] ACT_CLEAR  = 2'd2;

    localparam logic REG_ENABLE   = 1'b0;
    localparam logic REG_INTERVAL = 1'b1;

    typedef enum logic [1:0] {
        CMD_SAMPLE,
        CMD_REPORT,
        CMD_CLEAR
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t     op;
        logic [2:0]  slot;
        logic [31:0] dur;
    } cmd_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_LOAD,
        B_DIV,
        B_PUSH
    } back_state_t;

    typedef struct packed {
        logic        start;
        logic [63:0] dividend;
        logic [31:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [31:0] quotient;
    } div_rsp_t;

    typedef struct packed {
        logic [2:0]  slot_index;
        logic [31:0] sample_count;
        logic [31:0] min_duration;
        logic [31:0] avg_duration;
        logic [31:0] max_duration;
        logic        last;
    } res_t;

endpackage

### rtl/psd_front.sv
// ----------------------------------------------------------------------------
// psd_front
// Accepts input beats, keeps the tick counter and queues classified commands.
// ----------------------------------------------------------------------------
module psd_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  logic [1:0]          action,
    input  logic [2:0]          slot,
    input  logic [31:0]         elapsed_us,
    input  logic                enable,
    input  logic [19:0]         report_interval,
    output psd_pkg::cmd_t       cmd,
    output logic                cmd_valid,
    input  logic                cmd_pop
);

    psd_pkg::cmd_t                 mem [psd_pkg::CMD_DEPTH];
    logic [psd_pkg::CMD_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [psd_pkg::CMD_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [psd_pkg::CMD_CNT_W-1:0] cnt_reg, cnt_next;
    logic [31:0]                   tick_reg, tick_next;
    logic [31:0]                   tick_inc;
    logic                          accept;
    logic                          cls_valid;
    psd_pkg::cmd_op_t              cls_op;
    logic                          wr_en;
    logic                          rd_en;

    function automatic logic [psd_pkg::CMD_PTR_W-1:0] ptr_inc(
        input logic [psd_pkg::CMD_PTR_W-1:0] p
    );
        if (p == psd_pkg::CMD_PTR_W'(psd_pkg::CMD_DEPTH - 1))
        begin
            return '0;
        end
        return p + 1'b1;
    endfunction

    assign full      = (cnt_reg == psd_pkg::CMD_CNT_W'(psd_pkg::CMD_DEPTH));
    assign accept    = push && !full;
    assign cmd_valid = (cnt_reg != '0);
    assign cmd       = mem[rd_ptr_reg];
    assign tick_inc  = (tick_reg == psd_pkg::ALL_ONES32) ? tick_reg : tick_reg + 32'd1;

    always_comb
    begin
        cls_valid = 1'b0;
        cls_op    = psd_pkg::CMD_SAMPLE;
        tick_next = tick_reg;
        case (action)
            psd_pkg::ACT_SAMPLE:
            begin
                cls_valid = enable && (32'(slot) < 32'(psd_pkg::NUM_SLOTS));
                cls_op    = psd_pkg::CMD_SAMPLE;
            end
            psd_pkg::ACT_TICK:
            begin
                if (enable && (tick_inc >= {12'd0, report_interval}))
                begin
                    cls_valid = 1'b1;
                    cls_op    = psd_pkg::CMD_REPORT;
                    tick_next = '0;
                end
                else
                begin
                    tick_next = tick_inc;
                end
            end
            psd_pkg::ACT_CLEAR:
            begin
                cls_valid = 1'b1;
                cls_op    = psd_pkg::CMD_CLEAR;
                tick_next = '0;
            end
            default:
            begin
                cls_valid = 1'b0;
            end
        endcase
    end

    assign wr_en = accept && cls_valid;
    assign rd_en = cmd_pop && cmd_valid;

    always_comb
    begin
        wr_ptr_next = wr_en ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = rd_en ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        cnt_next    = cnt_reg + psd_pkg::CMD_CNT_W'(wr_en) - psd_pkg::CMD_CNT_W'(rd_en);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
            tick_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
            if (accept)
            begin
                tick_reg <= tick_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_ptr_reg] <= '{op: cls_op, slot: slot, dur: elapsed_us};
        end
    end

endmodule

### rtl/psd_div.sv
// ----------------------------------------------------------------------------
// psd_div
// Restoring divider, 64-bit dividend by 32-bit divisor, one bit per cycle.
// ----------------------------------------------------------------------------
module psd_div (
    input  logic              clk,
    input  logic              rst_n,
    input  psd_pkg::div_req_t req,
    output psd_pkg::div_rsp_t rsp
);

    logic [63:0]                   num_reg, num_next;
    logic [31:0]                   rem_reg, rem_next;
    logic [31:0]                   dvs_reg;
    logic [psd_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic                          busy_reg;
    logic                          done_reg;
    logic [32:0]                   shifted;
    logic [32:0]                   diff;
    logic                          ge;

    assign shifted = {rem_reg, num_reg[63]};
    assign diff    = shifted - {1'b0, dvs_reg};
    assign ge      = (shifted >= {1'b0, dvs_reg});

    always_comb
    begin
        rem_next = ge ? diff[31:0] : shifted[31:0];
        num_next = {num_reg[62:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == psd_pkg::DIV_CNT_W'(psd_pkg::DIV_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start && !busy_reg)
        begin
            num_reg <= req.dividend;
            rem_reg <= '0;
            dvs_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            num_reg <= num_next;
            rem_reg <= rem_next;
        end
    end

    assign rsp = '{busy: busy_reg, done: done_reg, quotient: num_reg[31:0]};

endmodule

### rtl/psd_back.sv
// ----------------------------------------------------------------------------
// psd_back
// Holds the slot statistics, executes queued commands and walks reports.
// ----------------------------------------------------------------------------
module psd_back (
    input  logic               clk,
    input  logic               rst_n,
    input  psd_pkg::cmd_t      cmd,
    input  logic               cmd_valid,
    output logic               cmd_pop,
    output psd_pkg::div_req_t  div_req,
    input  psd_pkg::div_rsp_t  div_rsp,
    output logic               empty,
    input  logic               pop,
    output psd_pkg::res_t      res
);

    logic [31:0] count_reg [psd_pkg::NUM_SLOTS];
    logic [31:0] min_reg   [psd_pkg::NUM_SLOTS];
    logic [31:0] max_reg   [psd_pkg::NUM_SLOTS];
    logic [63:0] sum_reg   [psd_pkg::NUM_SLOTS];
    logic [psd_pkg::NUM_SLOTS-1:0] seen_reg;

    psd_pkg::back_state_t          state_reg, state_next;
    logic [psd_pkg::IDX_W-1:0]     walk_reg, walk_next;
    psd_pkg::res_t                 pend_reg;

    psd_pkg::res_t                 omem [psd_pkg::OUT_DEPTH];
    logic [psd_pkg::OUT_PTR_W-1:0] owr_reg, ord_reg;
    logic [psd_pkg::OUT_CNT_W-1:0] ocnt_reg;
    logic                          ofull;
    logic                          opush;
    logic                          opop;

    logic                          do_sample;
    logic                          do_clear_all;
    logic                          do_load;
    logic                          do_avg;
    logic [psd_pkg::IDX_W-1:0]     sidx;
    logic [psd_pkg::IDX_W-1:0]     widx;
    logic                          walk_last;

    function automatic logic [psd_pkg::OUT_PTR_W-1:0] optr_inc(
        input logic [psd_pkg::OUT_PTR_W-1:0] p
    );
        if (p == psd_pkg::OUT_PTR_W'(psd_pkg::OUT_DEPTH - 1))
        begin
            return '0;
        end
        return p + 1'b1;
    endfunction

    assign sidx      = cmd.slot[psd_pkg::IDX_W-1:0];
    assign widx      = walk_reg;
    assign walk_last = (walk_reg == psd_pkg::IDX_W'(psd_pkg::NUM_SLOTS - 1));
    assign ofull     = (ocnt_reg == psd_pkg::OUT_CNT_W'(psd_pkg::OUT_DEPTH));
    assign empty     = (ocnt_reg == '0);
    assign opop      = pop && !empty;
    assign res       = omem[ord_reg];

    always_comb
    begin
        state_next       = state_reg;
        walk_next        = walk_reg;
        cmd_pop          = 1'b0;
        do_sample        = 1'b0;
        do_clear_all     = 1'b0;
        do_load          = 1'b0;
        do_avg           = 1'b0;
        opush            = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = sum_reg[widx];
        div_req.divisor  = count_reg[widx];
        case (state_reg)
            psd_pkg::B_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop = 1'b1;
                    case (cmd.op)
                        psd_pkg::CMD_SAMPLE:
                        begin
                            do_sample = 1'b1;
                        end
                        psd_pkg::CMD_REPORT:
                        begin
                            walk_next  = '0;
                            state_next = psd_pkg::B_LOAD;
                        end
                        psd_pkg::CMD_CLEAR:
                        begin
                            do_clear_all = 1'b1;
                        end
                        default:
                        begin
                            do_clear_all = 1'b0;
                        end
                    endcase
                end
            end
            psd_pkg::B_LOAD:
            begin
                do_load = 1'b1;
                if (count_reg[widx] != '0)
                begin
                    div_req.start = 1'b1;
                    state_next    = psd_pkg::B_DIV;
                end
                else
                begin
                    state_next = psd_pkg::B_PUSH;
                end
            end
            psd_pkg::B_DIV:
            begin
                if (div_rsp.done)
                begin
                    do_avg     = 1'b1;
                    state_next = psd_pkg::B_PUSH;
                end
            end
            psd_pkg::B_PUSH:
            begin
                if (!ofull)
                begin
                    opush = 1'b1;
                    if (walk_last)
                    begin
                        state_next = psd_pkg::B_IDLE;
                    end
                    else
                    begin
                        walk_next  = walk_reg + 1'b1;
                        state_next = psd_pkg::B_LOAD;
                    end
                end
            end
            default:
            begin
                state_next = psd_pkg::B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= psd_pkg::B_IDLE;
            walk_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            walk_reg  <= walk_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < psd_pkg::NUM_SLOTS; i++)
            begin
                count_reg[i] <= '0;
                min_reg[i]   <= psd_pkg::ALL_ONES32;
                max_reg[i]   <= '0;
                sum_reg[i]   <= '0;
            end
            seen_reg <= '0;
        end
        else if (do_clear_all)
        begin
            for (int i = 0; i < psd_pkg::NUM_SLOTS; i++)
            begin
                count_reg[i] <= '0;
                min_reg[i]   <= psd_pkg::ALL_ONES32;
                max_reg[i]   <= '0;
                sum_reg[i]   <= '0;
            end
            seen_reg <= '0;
        end
        else if (do_sample)
        begin
            count_reg[sidx] <= count_reg[sidx] + 32'd1;
            if (!seen_reg[sidx] || (cmd.dur < min_reg[sidx]))
            begin
                min_reg[sidx] <= cmd.dur;
            end
            if (!seen_reg[sidx] || (cmd.dur > max_reg[sidx]))
            begin
                max_reg[sidx] <= cmd.dur;
            end
            sum_reg[sidx]  <= sum_reg[sidx] + {32'd0, cmd.dur};
            seen_reg[sidx] <= 1'b1;
        end
        else if (do_load)
        begin
            count_reg[widx] <= '0;
            min_reg[widx]   <= psd_pkg::ALL_ONES32;
            max_reg[widx]   <= '0;
            sum_reg[widx]   <= '0;
            seen_reg[widx]  <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_load)
        begin
            pend_reg.slot_index   <= 3'(walk_reg);
            pend_reg.sample_count <= count_reg[widx];
            pend_reg.min_duration <= seen_reg[widx] ? min_reg[widx] : '0;
            pend_reg.max_duration <= seen_reg[widx] ? max_reg[widx] : '0;
            pend_reg.avg_duration <= '0;
            pend_reg.last         <= walk_last;
        end
        else if (do_avg)
        begin
            pend_reg.avg_duration <= div_rsp.quotient;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            owr_reg  <= '0;
            ord_reg  <= '0;
            ocnt_reg <= '0;
        end
        else
        begin
            if (opush)
            begin
                owr_reg <= optr_inc(owr_reg);
            end
            if (opop)
            begin
                ord_reg <= optr_inc(ord_reg);
            end
            ocnt_reg <= ocnt_reg + psd_pkg::OUT_CNT_W'(opush) - psd_pkg::OUT_CNT_W'(opop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (opush)
        begin
            omem[owr_reg] <= pend_reg;
        end
    end

endmodule

### rtl/per_slot_duration_statistics_core.sv
// ----------------------------------------------------------------------------
// per_slot_duration_statistics_core
// A sample or clear beat is queued when accepted and applied when psd_back pops it in B_IDLE.
// Throughput: one sample, tick or clear beat per cycle while the command queue drains.
// A report walks the slots in slot order through B_LOAD, B_DIV (64-step serial divider,
// non-empty slots only) and B_PUSH; the command queue holds further beats meanwhile.
// Reset clears slots, tick counter and queues; enable=0, report_interval=1000.
// ----------------------------------------------------------------------------
module per_slot_duration_statistics_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  action,
    input  logic [2:0]  slot,
    input  logic [31:0] elapsed_us,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  slot_index,
    output logic [31:0] sample_count,
    output logic [31:0] min_duration,
    output logic [31:0] avg_duration,
    output logic [31:0] max_duration,
    output logic        last
);

    logic              enable_reg;
    logic [19:0]       interval_reg;
    logic              cfg_wr;
    psd_pkg::cmd_t     cmd;
    logic              cmd_valid;
    logic              cmd_pop;
    psd_pkg::div_req_t div_req;
    psd_pkg::div_rsp_t div_rsp;
    psd_pkg::res_t     res;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg   <= 1'b0;
            interval_reg <= psd_pkg::INTERVAL_RESET;
        end
        else if (cfg_wr)
        begin
            case (paddr[2])
                psd_pkg::REG_ENABLE:   enable_reg   <= pwdata[0];
                psd_pkg::REG_INTERVAL: interval_reg <= pwdata[19:0];
                default:               enable_reg   <= enable_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            psd_pkg::REG_ENABLE:   prdata = {31'd0, enable_reg};
            psd_pkg::REG_INTERVAL: prdata = {12'd0, interval_reg};
            default:               prdata = '0;
        endcase
    end

    psd_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .action          (action),
        .slot            (slot),
        .elapsed_us      (elapsed_us),
        .enable          (enable_reg),
        .report_interval (interval_reg),
        .cmd             (cmd),
        .cmd_valid       (cmd_valid),
        .cmd_pop         (cmd_pop)
    );

    psd_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    psd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop),
        .div_req   (div_req),
        .div_rsp   (div_rsp),
        .empty     (empty),
        .pop       (pop),
        .res       (res)
    );

    assign slot_index   = res.slot_index;
    assign sample_count = res.sample_count;
    assign min_duration = res.min_duration;
    assign avg_duration = res.avg_duration;
    assign max_duration = res.max_duration;
    assign last         = res.last;

    a_pop_needs_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> cmd_valid)
        else $error("command popped from empty queue");

    a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("divider started while busy");

    a_div_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |=> div_rsp.busy)
        else $error("divider did not take start");

    a_enable_write: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_wr && (paddr[2] == psd_pkg::REG_ENABLE)) |=> (enable_reg == $past(pwdata[0])))
        else $error("enable register not written");

endmodule

### dv/tb_per_slot_duration_statistics_core.sv
// ----------------------------------------------------------------------------
// tb_per_slot_duration_statistics_core
// Self-checking bench for the per-slot duration statistics core. Sample,
// tick, clear and unused beats go in through the input queue port while
// enable and report_interval are set over APB between phases. A predictor
// tracks count, min, max and sum per slot along with the tick counter. It
// builds the expected report lines, which are compared field by field with
// every popped result. Both sides idle at random, with one calm phase and
// one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_per_slot_duration_statistics_core;

    import psd_pkg::*;

    localparam logic [1:0] ACT_UNUSED    = 2'd3;
    localparam int         IDLE_PCT      = 6;
    localparam int         HOLD_CYCLES   = 600;
    localparam int         SETTLE_CYCLES = 40;
    localparam int         STALL_LIMIT   = 20000;

    typedef struct packed {
        logic [1:0]  action;
        logic [2:0]  slot;
        logic [31:0] dur;
    } beat_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        push = 1'b0;
    logic        full;
    logic [1:0]  action = '0;
    logic [2:0]  slot = '0;
    logic [31:0] elapsed_us = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic [2:0]  slot_index;
    logic [31:0] sample_count;
    logic [31:0] min_duration;
    logic [31:0] avg_duration;
    logic [31:0] max_duration;
    logic        last;

    beat_t       beats_to_send[$];
    res_t        expected_lines[$];

    logic [31:0] win_count [NUM_SLOTS];
    logic [31:0] win_min [NUM_SLOTS];
    logic [31:0] win_max [NUM_SLOTS];
    logic [63:0] win_sum [NUM_SLOTS];
    logic        win_seen [NUM_SLOTS];
    logic [31:0] tick_count;
    logic        cfg_enable;
    logic [19:0] cfg_interval;

    logic        in_beat = 1'b0;
    bit          calm = 1'b0;
    bit          hold_go = 1'b0;
    bit          hold_done = 1'b0;
    int          hold_count = 0;
    int          mismatches = 0;
    int          quiet_cycles = 0;

    per_slot_duration_statistics_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .push         (push),
        .full         (full),
        .action       (action),
        .slot         (slot),
        .elapsed_us   (elapsed_us),
        .empty        (empty),
        .pop          (pop),
        .slot_index   (slot_index),
        .sample_count (sample_count),
        .min_duration (min_duration),
        .avg_duration (avg_duration),
        .max_duration (max_duration),
        .last         (last)
    );

    always #4 clk = ~clk;

    task automatic clear_windows();
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            win_count[i] = '0;
            win_min[i]   = ALL_ONES32;
            win_max[i]   = '0;
            win_sum[i]   = '0;
            win_seen[i]  = 1'b0;
        end
        tick_count = '0;
    endtask

    task automatic fold_beat_into_windows(input beat_t b);
        logic [63:0] quotient;
        res_t        line;
        int          s;
        s = int'(b.slot);
        case (b.action)
            ACT_SAMPLE:
            begin
                if (cfg_enable && s < NUM_SLOTS)
                begin
                    win_count[s] = win_count[s] + 32'd1;
                    if (!win_seen[s] || b.dur < win_min[s])
                        win_min[s] = b.dur;
                    if (!win_seen[s] || b.dur > win_max[s])
                        win_max[s] = b.dur;
                    win_sum[s]  = win_sum[s] + {32'd0, b.dur};
                    win_seen[s] = 1'b1;
                end
            end
            ACT_TICK:
            begin
                if (tick_count != ALL_ONES32)
                    tick_count = tick_count + 32'd1;
                if (cfg_enable && tick_count >= {12'd0, cfg_interval})
                begin
                    for (int i = 0; i < NUM_SLOTS; i++)
                    begin
                        quotient = '0;
                        if (win_count[i] != 0)
                            quotient = win_sum[i] / {32'd0, win_count[i]};
                        line.slot_index   = 3'(i);
                        line.sample_count = win_count[i];
                        line.min_duration = win_seen[i] ? win_min[i] : 32'd0;
                        line.avg_duration = quotient[31:0];
                        line.max_duration = win_seen[i] ? win_max[i] : 32'd0;
                        line.last         = (i == NUM_SLOTS - 1);
                        expected_lines.push_back(line);
                    end
                    clear_windows();
                end
            end
            ACT_CLEAR:
                clear_windows();
            default:
                ;
        endcase
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endtask

    // Input monitor, predictor, result checker and watchdog
    always @(posedge clk)
    begin
        res_t want;
        in_beat <= push && !full;
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                if (expected_lines.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected result, expected none, actual slot %0d",
                             $time, slot_index);
                end
                else
                begin
                    want = expected_lines.pop_front();
                    check_field("slot_index", 32'(want.slot_index), 32'(slot_index));
                    check_field("sample_count", want.sample_count, sample_count);
                    check_field("min_duration", want.min_duration, min_duration);
                    check_field("avg_duration", want.avg_duration, avg_duration);
                    check_field("max_duration", want.max_duration, max_duration);
                    check_field("last", 32'(want.last), 32'(last));
                end
            end
            if (push && !full)
                fold_beat_into_windows('{action, slot, elapsed_us});
            if ((pop && !empty) || (push && !full) || (psel && penable && pwrite))
                quiet_cycles <= 0;
            else if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("%0t: timeout, no beat for %0d cycles", $time, STALL_LIMIT);
                $display("Verification failed");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Input driver
    always @(negedge clk)
    begin
        if (in_beat)
            beats_to_send.delete(0);
        if (!(push && !in_beat))
        begin
            if (rst_n && beats_to_send.size() != 0 &&
                (calm || $urandom_range(99) >= IDLE_PCT))
            begin
                push       <= 1'b1;
                action     <= beats_to_send[0].action;
                slot       <= beats_to_send[0].slot;
                elapsed_us <= beats_to_send[0].dur;
            end
            else
                push <= 1'b0;
        end
    end

    // Result receiver
    always @(negedge clk)
    begin
        if (hold_go && !hold_done)
        begin
            pop        <= 1'b0;
            hold_count <= hold_count + 1;
            if (hold_count == HOLD_CYCLES - 1)
                hold_done <= 1'b1;
        end
        else
            pop <= calm || ($urandom_range(99) >= IDLE_PCT);
    end

    task automatic write_reg(input logic idx, input logic [31:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_ENABLE)
            cfg_enable = value[0];
        else
            cfg_interval = value[19:0];
        @(posedge clk);
    endtask

    task automatic queue_beat(input logic [1:0] a, input logic [2:0] s,
                              input logic [31:0] d);
        beats_to_send.push_back('{a, s, d});
    endtask

    task automatic settle();
        while (beats_to_send.size() != 0 || expected_lines.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic random_burst(input int n);
        logic [1:0]  a;
        logic [31:0] d;
        int          pick;
        for (int k = 0; k < n; k++)
        begin
            pick = $urandom_range(99);
            if (pick < 58)
                a = ACT_SAMPLE;
            else if (pick < 88)
                a = ACT_TICK;
            else if (pick < 94)
                a = ACT_CLEAR;
            else
                a = ACT_UNUSED;
            case ($urandom_range(3))
                0: d = $urandom();
                1: d = $urandom_range(1000);
                2: d = ALL_ONES32 - $urandom_range(3);
                default: d = $urandom_range(3);
            endcase
            queue_beat(a, 3'($urandom_range(NUM_SLOTS - 1)), d);
        end
    endtask

    initial
    begin
        cfg_enable   = 1'b0;
        cfg_interval = INTERVAL_RESET;
        clear_windows();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // disabled: sample dropped, ticks still advance
        queue_beat(ACT_SAMPLE, 3'd1, 32'd123);
        queue_beat(ACT_TICK, 3'd5, $urandom());
        queue_beat(ACT_TICK, 3'd2, $urandom());
        settle();

        write_reg(REG_ENABLE, 32'd1);
        write_reg(REG_INTERVAL, 32'd3);
        queue_beat(ACT_SAMPLE, 3'd0, 32'd0);
        queue_beat(ACT_SAMPLE, 3'd0, ALL_ONES32);
        queue_beat(ACT_SAMPLE, 3'd7, ALL_ONES32);
        queue_beat(ACT_SAMPLE, 3'd3, 32'd5);
        queue_beat(ACT_SAMPLE, 3'd3, 32'hFFFF_FFFE);
        queue_beat(ACT_SAMPLE, 3'd3, 32'd1);
        queue_beat(ACT_UNUSED, 3'd5, 32'd77);
        queue_beat(ACT_TICK, 3'd0, 32'd0);
        queue_beat(ACT_SAMPLE, 3'd2, 32'd9);
        queue_beat(ACT_CLEAR, 3'd7, ALL_ONES32);
        queue_beat(ACT_SAMPLE, 3'd4, ALL_ONES32);
        queue_beat(ACT_SAMPLE, 3'd4, ALL_ONES32);
        queue_beat(ACT_TICK, 3'd1, 32'd0);
        queue_beat(ACT_TICK, 3'd6, 32'd0);
        queue_beat(ACT_TICK, 3'd7, 32'd0);
        settle();

        write_reg(REG_INTERVAL, 32'd0);
        queue_beat(ACT_SAMPLE, 3'd6, 32'h8000_0000);
        queue_beat(ACT_TICK, 3'd3, 32'd0);
        queue_beat(ACT_TICK, 3'd4, 32'd0);
        settle();

        write_reg(REG_INTERVAL, 32'($urandom_range(2, 6)));
        random_burst(80);
        settle();

        calm = 1'b1;
        write_reg(REG_INTERVAL, 32'd2);
        random_burst(50);
        settle();
        calm = 1'b0;

        // long receiver hold-off while the sender keeps offering
        write_reg(REG_INTERVAL, 32'd1);
        hold_go = 1'b1;
        random_burst(40);
        settle();

        write_reg(REG_INTERVAL, 32'hF_FFFF);
        random_burst(30);
        queue_beat(ACT_CLEAR, 3'd0, 32'd0);
        settle();

        write_reg(REG_ENABLE, 32'd0);
        write_reg(REG_INTERVAL, 32'd3);
        random_burst(20);
        settle();

        write_reg(REG_ENABLE, 32'd1);
        write_reg(REG_INTERVAL, 32'd0);
        random_burst(40);
        settle();

        if (mismatches == 0 && expected_lines.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
